// ===== rtl/core/pts_pkg.sv =====
// Shared types and constants for the prime test and search core.
`timescale 1ns / 1ps
package pts_pkg;

  // Default datapath width handed to the top level.
  localparam int PTS_WIDTH = 32;

  // Request opcodes.
  localparam logic [1:0] OP_TEST = 2'd0;
  localparam logic [1:0] OP_NEXT = 2'd1;
  localparam logic [1:0] OP_PREV = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        is_prime;
    logic        found;
  } rsp_t;

  // Status of the remainder unit toward the sequencer.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

// ===== rtl/core/pts_rem_unit.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module pts_rem_unit #(
  parameter int DW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [DW-1:0]       divisor,
  output pts_pkg::rem_stat_t  stat
);
  import pts_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] sh;
  logic [DW:0]   rem;
  logic [DW:0]   trial;
  logic [DW:0]   dvs;
  logic          ge;

  assign dvs   = {1'b0, divisor};
  assign trial = {rem[DW-1:0], sh[DW-1]};
  assign ge    = trial >= dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        sh   <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? (trial - dvs) : trial;
        sh  <= sh << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.zero = (rem == '0);

endmodule

// ===== rtl/core/prime_test_and_search_core.sv =====
// Top level: trial-division primality test and nearest-prime search sequencer.
`timescale 1ns / 1ps
// Each request item carries an opcode and a 32-bit value; each gives exactly one
// response item. Opcode 0 tests the value for primality, opcode 1 returns the
// smallest prime at or above it, opcode 2 the largest prime at or below it;
// opcode 3 returns the value with both flags clear. A failed search (upward past
// 2^DW-1, or downward from 0 or 1) returns the input with found clear, where
// DW = min(WIDTH,32); the value is masked to DW bits first. The core works on one
// item at a time and drops req_ready until its response has been loaded into the
// output register; a waiting response does not block the next request. Timing is
// data dependent and set by the bit-serial remainder unit: testing an odd
// candidate n runs one division per odd divisor d from 3 while d*d <= n, and each
// division steps through all DW dividend bits; even or small values skip the
// divisor walk. A search repeats that test once per odd candidate across the
// prime gap it walks.
module prime_test_and_search_core #(
  parameter int WIDTH = pts_pkg::PTS_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pts_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pts_pkg::rsp_t rsp
);
  import pts_pkg::*;

  // Working width: the result field is 32 bits, so clip there.
  localparam int DW = (WIDTH >= 32) ? 32 : WIDTH;
  localparam logic [DW-1:0] VMAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_TEST,
    S_CHECK,
    S_WAIT,
    S_CAND,
    S_FINISH
  } state_t;

  state_t        state;
  logic [1:0]    op;
  logic [DW-1:0] v;         // masked request value
  logic [DW-1:0] c;         // current candidate
  logic [DW-1:0] d;         // current odd divisor
  logic [DW+1:0] sq;        // d * d, kept by running sums
  logic [DW+1:0] inc;       // (d+2)^2 - d^2 = 4d + 4
  logic          cand_prime;
  logic [DW-1:0] res_val;
  logic          res_prime;
  logic          res_found;
  logic          rem_start;
  rem_stat_t     rem_stat;

  assign req_ready = (state == S_IDLE);

  pts_rem_unit #(
    .DW(DW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (c),
    .divisor  (d),
    .stat     (rem_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rem_start <= 1'b0;
    end else begin
      rem_start <= 1'b0;
      // Drop the response once taken, unless a new one is loaded this cycle.
      if (rsp_valid && rsp_ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.opcode;
            v     <= req.value[DW-1:0];
            state <= S_INIT;
          end
        end

        // Sort out the trivial cases and pick the first candidate.
        S_INIT: begin
          res_val   <= v;
          res_prime <= 1'b0;
          res_found <= 1'b0;
          case (op)
            OP_TEST: begin
              c     <= v;
              state <= S_TEST;
            end
            OP_NEXT: begin
              if (v <= DW'(2)) begin
                res_val   <= DW'(2);
                res_prime <= 1'b1;
                res_found <= 1'b1;
                state     <= S_FINISH;
              end else begin
                c     <= v | DW'(1);
                state <= S_TEST;
              end
            end
            OP_PREV: begin
              if (v < DW'(2)) begin
                state <= S_FINISH;
              end else if (v == DW'(2)) begin
                res_val   <= DW'(2);
                res_prime <= 1'b1;
                res_found <= 1'b1;
                state     <= S_FINISH;
              end else begin
                c     <= v[0] ? v : (v - DW'(1));
                state <= S_TEST;
              end
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end

        // Quick screen of the candidate, else arm the divisor walk at 3.
        S_TEST: begin
          if (c < DW'(2)) begin
            cand_prime <= 1'b0;
            state      <= S_CAND;
          end else if (!c[0]) begin
            cand_prime <= (c == DW'(2));
            state      <= S_CAND;
          end else begin
            d     <= DW'(3);
            sq    <= (DW + 2)'(9);
            inc   <= (DW + 2)'(16);
            state <= S_CHECK;
          end
        end

        // Stop once d*d passes the candidate; otherwise divide.
        S_CHECK: begin
          if (sq > {2'b00, c}) begin
            cand_prime <= 1'b1;
            state      <= S_CAND;
          end else begin
            rem_start <= 1'b1;
            state     <= S_WAIT;
          end
        end

        S_WAIT: begin
          if (rem_stat.done) begin
            if (rem_stat.zero) begin
              cand_prime <= 1'b0;
              state      <= S_CAND;
            end else begin
              d     <= d + DW'(2);
              sq    <= sq + inc;
              inc   <= inc + (DW + 2)'(8);
              state <= S_CHECK;
            end
          end
        end

        // Act on the candidate verdict according to the opcode.
        S_CAND: begin
          case (op)
            OP_NEXT: begin
              if (cand_prime) begin
                res_val   <= c;
                res_prime <= 1'b1;
                res_found <= 1'b1;
                state     <= S_FINISH;
              end else if (c == VMAX) begin
                state <= S_FINISH;
              end else begin
                c     <= c + DW'(2);
                state <= S_TEST;
              end
            end
            OP_PREV: begin
              if (cand_prime) begin
                res_val   <= c;
                res_prime <= 1'b1;
                res_found <= 1'b1;
                state     <= S_FINISH;
              end else if (c == DW'(3)) begin
                res_val   <= DW'(2);
                res_prime <= 1'b1;
                res_found <= 1'b1;
                state     <= S_FINISH;
              end else begin
                c     <= c - DW'(2);
                state <= S_TEST;
              end
            end
            default: begin
              res_prime <= cand_prime;
              res_found <= 1'b1;
              state     <= S_FINISH;
            end
          endcase
        end

        // Hold the response until the output register is free.
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid        <= 1'b1;
            rsp.result_value <= 32'(res_val);
            rsp.is_prime     <= res_prime;
            rsp.found        <= res_found;
            state            <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A failed search or unused opcode never reports a prime.
  a_notfound_notprime: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |-> !rsp.is_prime)
    else $error("response without found flag claims a prime");

  // A successful search always lands on a prime.
  a_search_prime: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && op != OP_TEST && res_found) |-> res_prime)
    else $error("search reported found without a prime");

  // Divisor walk stays on odd divisors of at least three.
  a_divisor_odd: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (d[0] && d >= DW'(3)))
    else $error("trial divisor left the odd sequence");

  // The remainder unit only finishes while the sequencer waits on it.
  a_rem_done_wait: assert property (@(posedge clk) disable iff (rst)
    rem_stat.done |-> (state == S_WAIT))
    else $error("remainder finished outside the wait state");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("core still ready after accepting an item");

endmodule
